// ===== rtl/sh24_pkg.sv =====
// Shared types, constants and round functions for the SipHash-2-4 stream hasher.
// Used by sh24_compress, sh24_finish and siphash_2_4_stream. No dependencies.
`timescale 1ns / 1ps

package sh24_pkg;

    // Initialization constants ("somepseudorandomlygeneratedbytes")
    localparam logic [63:0] SIP_C0    = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1    = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2    = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3    = 64'h7465646279746573;
    localparam logic [7:0]  SIP_FINAL = 8'hff;

    // Configuration register indexes
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    // Bytes in a full word
    localparam logic [3:0] WORD_BYTES = 4'd8;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_lanes;

    // Word handed from the absorb stage to the finalization pipe
    typedef struct packed {
        logic        valid;
        t_lanes      lanes;
        logic [63:0] tail;
    } t_stage;

    function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned s);
        rotl = (x << s) | (x >> (64 - s));
    endfunction

    // One SipRound
    function automatic t_lanes sip_round(input t_lanes v);
        t_lanes r;
        r   = v;
        r.a = r.a + r.b;
        r.b = rotl(r.b, 13) ^ r.a;
        r.a = rotl(r.a, 32);
        r.c = r.c + r.d;
        r.d = rotl(r.d, 16) ^ r.c;
        r.a = r.a + r.d;
        r.d = rotl(r.d, 21) ^ r.a;
        r.c = r.c + r.b;
        r.b = rotl(r.b, 17) ^ r.c;
        r.c = rotl(r.c, 32);
        return r;
    endfunction

    function automatic t_lanes sip_rounds2(input t_lanes v);
        return sip_round(sip_round(v));
    endfunction

    // Absorb one 64-bit block with two rounds
    function automatic t_lanes sip_absorb(input t_lanes v, input logic [63:0] m);
        t_lanes r;
        r   = v;
        r.d = r.d ^ m;
        r   = sip_rounds2(r);
        r.a = r.a ^ m;
        return r;
    endfunction

endpackage

// ===== rtl/sh24_compress.sv =====
// Absorb stage: lane registers, message length and fresh flag, plus the
// register that hands a finished message's lanes and tail block to sh24_finish. Uses sh24_pkg.
`timescale 1ns / 1ps

module sh24_compress
    import sh24_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    input  logic [63:0] i_key_low,
    input  logic [63:0] i_key_high,
    input  logic        i_next_free,
    output t_stage      o_stage
);

    t_lanes      r_lanes;
    logic [7:0]  r_len;
    logic        r_fresh;
    t_stage      r_stage;

    t_lanes      n_start;
    t_lanes      n_absorbed;
    logic [7:0]  n_len_base;
    logic [7:0]  n_len;
    logic [3:0]  n_count;
    logic        n_full;
    logic [63:0] n_masked;
    logic [63:0] n_tail;

    // Lane start value, word absorb and tail block
    always_comb begin
        n_start.a  = r_fresh ? (SIP_C0 ^ i_key_low)  : r_lanes.a;
        n_start.b  = r_fresh ? (SIP_C1 ^ i_key_high) : r_lanes.b;
        n_start.c  = r_fresh ? (SIP_C2 ^ i_key_low)  : r_lanes.c;
        n_start.d  = r_fresh ? (SIP_C3 ^ i_key_high) : r_lanes.d;
        n_len_base = r_fresh ? 8'd0 : r_len;

        n_count = (i_byte_count > WORD_BYTES) ? WORD_BYTES : i_byte_count;
        // non-last words always use all eight bytes
        n_full  = !i_last_word || (n_count == WORD_BYTES);

        n_absorbed = n_full ? sip_absorb(n_start, i_message_word) : n_start;
        n_len      = n_len_base + (n_full ? {4'd0, WORD_BYTES} : {4'd0, n_count});

        for (int b = 0; b < 8; b++) begin
            n_masked[8*b +: 8] = (4'(b) < n_count) ? i_message_word[8*b +: 8] : 8'd0;
        end
        n_tail = (n_full ? 64'd0 : n_masked) | {n_len, 56'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes       <= '0;
            r_len         <= 8'd0;
            r_fresh       <= 1'b1;
            r_stage.valid <= 1'b0;
        end else begin
            if (i_accept && !i_last_word) begin
                r_lanes <= n_absorbed;
                r_len   <= n_len;
                r_fresh <= 1'b0;
            end else if (i_accept) begin
                r_len   <= 8'd0;
                r_fresh <= 1'b1;
            end

            // hand-off register toward finalization
            if (i_accept && i_last_word) begin
                r_stage.valid <= 1'b1;
                r_stage.lanes <= n_absorbed;
                r_stage.tail  <= n_tail;
            end else if (i_next_free) begin
                r_stage.valid <= 1'b0;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== rtl/sh24_finish.sv =====
// Finalization pipe: tail absorb, 0xff injection, four rounds and the tag fold,
// two rounds per stage, ending in the output register. Uses sh24_pkg.
`timescale 1ns / 1ps

module sh24_finish
    import sh24_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stage      i_stage,
    input  logic        i_stall,
    output logic        o_stage_free,
    output logic        o_valid,
    output logic [63:0] o_tag
);

    logic        r_s2_valid;
    t_lanes      r_s2;
    logic        r_s3_valid;
    t_lanes      r_s3;
    logic        r_out_valid;
    logic [63:0] r_tag;

    logic        n_out_free;
    logic        n_s3_free;
    logic        n_s2_free;
    t_lanes      n_s2;
    t_lanes      n_s3;
    t_lanes      n_fin;

    // Each stage moves when the one after it is empty or moving
    assign n_out_free   = !r_out_valid || !i_stall;
    assign n_s3_free    = !r_s3_valid || n_out_free;
    assign n_s2_free    = !r_s2_valid || n_s3_free;
    assign o_stage_free = n_s2_free;

    always_comb begin
        n_s2   = sip_absorb(i_stage.lanes, i_stage.tail);
        n_s2.c = n_s2.c ^ {56'd0, SIP_FINAL};
        n_s3   = sip_rounds2(r_s2);
        n_fin  = sip_rounds2(r_s3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (n_s2_free) begin
                r_s2_valid <= i_stage.valid;
                r_s2       <= n_s2;
            end
            if (n_s3_free) begin
                r_s3_valid <= r_s2_valid;
                r_s3       <= n_s3;
            end
            if (n_out_free) begin
                r_out_valid <= r_s3_valid;
                r_tag       <= n_fin.a ^ n_fin.b ^ n_fin.c ^ n_fin.d;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_tag   = r_tag;

endmodule

// ===== rtl/siphash_2_4_stream.sv =====
// SipHash-2-4 stream hasher, top level: key registers, absorb stage, finalization pipe.
// Depends on sh24_pkg, sh24_compress and sh24_finish.
//
// Usage:
//  - Write the key halves through i_cfg_we / i_cfg_index / i_cfg_data while idle
//    (index 0 = key_low, index 1 = key_high).
//  - Message words come in on i_valid / o_stall, one per cycle unless o_stall is high.
//    Non-last words always count as eight bytes; a last word carries 0..8 bytes
//    (counts above eight saturate, bytes beyond the count are ignored).
//  - The first word of a message loads the lanes from the key; a full word is
//    absorbed in the cycle it is accepted, two rounds in the lane loop.
//  - A last word produces one tag on o_valid / i_stall. From acceptance to o_valid
//    it passes the absorb stage's hand-off register, then three finalization stages
//    of two rounds each (tail block, then the four final rounds and the fold).
//  - One word per cycle while o_stall is low, set by the two-round lane feedback loop.
//  - When the receiver stalls, finished tags back up in the finalization pipe;
//    words keep being accepted until four tags are waiting, then o_stall rises.
//  - Reset clears the key, empties the pipe and makes the next word start a message.
`timescale 1ns / 1ps

module siphash_2_4_stream
    import sh24_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_tag
);

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;

    t_stage      stage;
    logic        stage_free;
    logic        accept;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 64'd0;
            r_key_high <= 64'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Input handshake: blocked only when the hand-off register cannot drain
    assign o_stall = stage.valid && !stage_free;
    assign accept  = i_valid && !o_stall;

    sh24_compress u_compress (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .i_key_low      (r_key_low),
        .i_key_high     (r_key_high),
        .i_next_free    (stage_free),
        .o_stage        (stage)
    );

    sh24_finish u_finish (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (stage),
        .i_stall      (i_stall),
        .o_stage_free (stage_free),
        .o_valid      (o_valid),
        .o_tag        (o_tag)
    );

endmodule

// ===== rtl/sh24_checker.sv =====
// Port-level checks for siphash_2_4_stream, attached by the bind below.
// No package dependency.
`timescale 1ns / 1ps

module sh24_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_word,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_tag
);

    // A held tag does not change
    a_tag_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tag))
        else $error("tag changed or dropped while stalled");

    // Input backpressure only when the output side is full and stalled
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output side can drain");

    // A tag rising on an empty output comes from an accepted last word
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall && i_last_word, 4))
        else $error("tag without matching last word");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind siphash_2_4_stream sh24_checker u_sh24_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last_word (i_last_word),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_tag       (o_tag)
);

// ===== test/testbench.sv =====
// Self-checking testbench for siphash_2_4_stream: directed rows, some with known tags,
// then random messages under several keys, checked against a SipHash-2-4 predictor.
// Depends on sh24_pkg and the siphash_2_4_stream RTL.
`timescale 1ns / 1ps

module testbench;
    import sh24_pkg::*;

    localparam int  N_DIRECTED   = 20;
    localparam int  ITEM_TARGET  = 800;
    localparam int  N_KEY_PHASES = 6;
    localparam int  MAX_IDLE     = 15;
    localparam int  SETTLE_CYC   = 8;     // allow margin for the pipe to empty
    localparam int  DRAIN_CYC    = 2000;
    localparam real TIMEOUT_NS   = 2_000_000.0;

    // Standard SipHash test key 00 01 .. 0f
    localparam logic [63:0] STD_KEY_LO = 64'h0706050403020100;
    localparam logic [63:0] STD_KEY_HI = 64'h0f0e0d0c0b0a0908;
    localparam logic [63:0] ALL_ONES   = 64'hffff_ffff_ffff_ffff;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_message_word;
    logic [3:0]  i_byte_count;
    logic        i_last_word;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_tag;

    siphash_2_4_stream DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_last_word    (i_last_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_tag          (o_tag)
    );

    // Directed stimulus row; tag is typed in only where it is a published vector
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        last;
        logic        known;
        logic [63:0] tag;
    } t_dir_row;

    t_dir_row directed_rows [N_DIRECTED] = '{
        // empty message, junk above the count
        '{64'hdeadbeef_cafef00d, 4'd0,  1'b1, 1'b1, 64'h726fdb47dd0e0e31},
        // one byte 00, upper bytes set and ignored
        '{64'hffff_ffff_ffff_ff00, 4'd1, 1'b1, 1'b1, 64'h74f839c593dc67fd},
        // eight bytes 00..07 as a full last word
        '{64'h0706050403020100, 4'd8,  1'b1, 1'b1, 64'h93f5f5799a932462},
        // same with count saturating from 15
        '{64'h0706050403020100, 4'd15, 1'b1, 1'b1, 64'h93f5f5799a932462},
        // fifteen bytes 00..0e: count on the non-last word is ignored
        '{64'h0706050403020100, 4'd3,  1'b0, 1'b0, 64'h0},
        '{64'haa0e0d0c0b0a0908, 4'd7,  1'b1, 1'b1, 64'ha129ca6149be45e5},
        // extremes of the word
        '{ALL_ONES,             4'd0,  1'b0, 1'b0, 64'h0},
        '{ALL_ONES,             4'd8,  1'b1, 1'b0, 64'h0},
        '{64'h0,                4'd0,  1'b1, 1'b1, 64'h726fdb47dd0e0e31},
        '{64'h0123456789abcdef, 4'd2,  1'b1, 1'b0, 64'h0},
        // the remaining partial counts, then a count of nine that saturates
        '{ALL_ONES,             4'd3,  1'b1, 1'b0, 64'h0},
        '{ALL_ONES,             4'd4,  1'b1, 1'b0, 64'h0},
        '{ALL_ONES,             4'd5,  1'b1, 1'b0, 64'h0},
        '{ALL_ONES,             4'd6,  1'b1, 1'b0, 64'h0},
        '{ALL_ONES,             4'd7,  1'b1, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0001, 4'd9, 1'b1, 1'b0, 64'h0},
        // multiword message with out-of-range counts on non-last words
        '{64'h0,                4'd12, 1'b0, 1'b0, 64'h0},
        '{ALL_ONES,             4'd15, 1'b0, 1'b0, 64'h0},
        '{64'hfedcba9876543210, 4'd0,  1'b1, 1'b0, 64'h0},
        // left open: the key changes before this message finishes
        '{64'h5555_aaaa_5555_aaaa, 4'd8, 1'b0, 1'b0, 64'h0}
    };

    // Predictor state
    logic [63:0] key_lo_shadow;
    logic [63:0] key_hi_shadow;
    logic [63:0] v0, v1, v2, v3;
    logic [7:0]  msg_len_byte;
    bit          at_msg_start;

    logic [63:0] tag_queue [$];
    int          error_count;
    int          words_sent;
    bit          calm;         // no idling on either side
    bit          rx_enable;

    // ---------------- predictor ----------------
    function automatic logic [63:0] rol64(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic void mix_round();
        v0 = v0 + v1;  v1 = rol64(v1, 13) ^ v0;  v0 = rol64(v0, 32);
        v2 = v2 + v3;  v3 = rol64(v3, 16) ^ v2;
        v0 = v0 + v3;  v3 = rol64(v3, 21) ^ v0;
        v2 = v2 + v1;  v1 = rol64(v1, 17) ^ v2;  v2 = rol64(v2, 32);
    endfunction

    function automatic void absorb_block(input logic [63:0] m);
        v3 = v3 ^ m;
        mix_round();
        mix_round();
        v0 = v0 ^ m;
    endfunction

    // Advance the hash by one word; returns 1 with the tag when a message closes
    function automatic bit hash_word(input logic [63:0] w, input logic [3:0] n,
                                     input logic l, output logic [63:0] tag);
        logic [3:0]  cnt;
        logic [63:0] blk;
        tag = '0;
        if (at_msg_start) begin
            v0 = SIP_C0 ^ key_lo_shadow;
            v1 = SIP_C1 ^ key_hi_shadow;
            v2 = SIP_C2 ^ key_lo_shadow;
            v3 = SIP_C3 ^ key_hi_shadow;
            msg_len_byte = '0;
            at_msg_start = 0;
        end
        if (!l) begin
            absorb_block(w);
            msg_len_byte = msg_len_byte + 8'd8;
            return 0;
        end
        cnt = (n > WORD_BYTES) ? WORD_BYTES : n;
        if (cnt == WORD_BYTES) begin
            absorb_block(w);
            msg_len_byte = msg_len_byte + 8'd8;
            blk = '0;
        end else begin
            blk = w & ((64'd1 << (8 * cnt)) - 64'd1);
            msg_len_byte = msg_len_byte + {4'd0, cnt};
        end
        blk[63:56] = msg_len_byte;
        absorb_block(blk);
        v2 = v2 ^ {56'd0, SIP_FINAL};
        repeat (4) mix_round();
        tag = v0 ^ v1 ^ v2 ^ v3;
        at_msg_start = 1;
        msg_len_byte = '0;
        return 1;
    endfunction

    // ---------------- clock ----------------
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ---------------- sender side ----------------
    // Called and returns at a falling edge. Valid stays high between
    // back-to-back words so it is never dropped and raised in one step.
    task automatic send_word(input logic [63:0] w, input logic [3:0] n, input logic l,
                             input bit known, input logic [63:0] known_tag);
        int          gap;
        logic [63:0] tag;
        gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_message_word <= w;
        i_byte_count   <= n;
        i_last_word    <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        if (hash_word(w, n, l, tag))
            tag_queue.push_back(known ? known_tag : tag);
        @(negedge i_clk);
    endtask

    // Wait at a falling edge until every tag is back, then let the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tag_queue.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Write both key halves back to back
    task automatic load_key(input logic [63:0] lo, input logic [63:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_KEY_LOW;
        i_cfg_data  <= lo;
        @(negedge i_clk);
        i_cfg_index <= REG_KEY_HIGH;
        i_cfg_data  <= hi;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        key_lo_shadow = lo;
        key_hi_shadow = hi;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // One well-formed message with random content
    task automatic send_message();
        int         n_body;
        logic [3:0] n_last;
        if ($urandom_range(0, 9) == 0)
            n_body = $urandom_range(30, 40);    // from 32 words on, long enough to wrap the length byte
        else
            n_body = $urandom_range(0, 4);
        for (int k = 0; k < n_body; k++)
            send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 0, '0);
        if ($urandom_range(0, 7) == 0)
            n_last = 4'($urandom_range(9, 15));
        else
            n_last = 4'($urandom_range(0, 8));
        send_word(rand_word(), n_last, 1'b1, 0, '0);
    endtask

    // ---------------- receiver side ----------------
    initial begin
        int          stall_left;
        logic [63:0] want;
        stall_left = 0;
        i_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_enable && o_valid && !i_stall) begin
                if (tag_queue.size() == 0) begin
                    $display("%0t: unexpected tag, expected none, got %h", $time, o_tag);
                    error_count++;
                end else begin
                    want = tag_queue.pop_front();
                    if (o_tag !== want) begin
                        $display("%0t: tag mismatch, expected %h, got %h",
                                 $time, want, o_tag);
                        error_count++;
                    end
                end
                stall_left = calm ? 0 : $urandom_range(0, MAX_IDLE);
            end
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        logic [63:0] lo, hi;
        int          drain;
        int          phase_budget;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_KEY_LOW;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_message_word = '0;
        i_byte_count   = '0;
        i_last_word    = 1'b0;
        error_count    = 0;
        words_sent     = 0;
        calm           = 0;
        rx_enable      = 0;
        key_lo_shadow  = '0;
        key_hi_shadow  = '0;
        v0 = '0; v1 = '0; v2 = '0; v3 = '0;
        msg_len_byte   = '0;
        at_msg_start   = 1;

        repeat (3) @(negedge i_clk);
        i_rst_n   <= 1'b1;
        rx_enable = 1;
        @(negedge i_clk);

        // directed rows under the standard test key
        load_key(STD_KEY_LO, STD_KEY_HI);
        foreach (directed_rows[r])
            send_word(directed_rows[r].word, directed_rows[r].count, directed_rows[r].last,
                      directed_rows[r].known, directed_rows[r].tag);
        wait_idle();

        // random messages, one key per phase; the sender drains fully between
        phase_budget = ITEM_TARGET / N_KEY_PHASES;
        for (int ph = 0; ph < N_KEY_PHASES; ph++) begin
            case (ph)
                0:       begin lo = '0;          hi = '0;          end
                1:       begin lo = ALL_ONES;    hi = ALL_ONES;    end
                3:       begin lo = '0;          hi = ALL_ONES;    end
                default: begin lo = rand_word(); hi = rand_word(); end
            endcase
            load_key(lo, hi);
            calm = (ph % 3 == 2);
            words_sent = 0;
            while (words_sent < phase_budget)
                send_message();
            // sometimes leave a message open across the key change
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, 3))
                    send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 0, '0);
            wait_idle();
        end
        // close any open message under the final key
        send_message();

        // drain what is left and settle
        i_valid <= 1'b0;
        drain = 0;
        while (tag_queue.size() != 0 && drain < DRAIN_CYC) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYC) @(negedge i_clk);
        while (tag_queue.size() != 0) begin
            $display("%0t: missing tag, expected %h, got none", $time, tag_queue.pop_front());
            error_count++;
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard limit on run length
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sh24_pkg.sv
rtl/sh24_compress.sv
rtl/sh24_finish.sv
rtl/siphash_2_4_stream.sv
rtl/sh24_checker.sv
test/testbench.sv
